FILE: sv/sack_block_table_defines.svh
// Assertion macros used by the table module of the block.
`ifndef SACK_BLOCK_TABLE_DEFINES_SVH
`define SACK_BLOCK_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SBT_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sack_block_table assertion failed");
`define SBT_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("sack_block_table assertion failed");
`else
`define SBT_ASSERT(label, prop)
`define SBT_ASSERT_ALWAYS(label, prop)
`endif

`endif

FILE: sv/sbt_pkg.sv
package sbt_pkg;

    localparam int EDGE_W   = 32;
    localparam int OP_W     = 2;
    localparam int REPORT_W = 3;

    typedef logic [OP_W-1:0] opcode_t;

    localparam opcode_t OP_ADD   = 2'd0;
    localparam opcode_t OP_QUERY = 2'd1;
    localparam opcode_t OP_CLEAR = 2'd2;

    typedef struct packed {
        opcode_t            opcode;
        logic [EDGE_W-1:0]  left_edge;
        logic [EDGE_W-1:0]  right_edge;
        logic [EDGE_W-1:0]  query_seq;
    } sbt_item_t;

    typedef struct packed {
        logic                hit;
        logic [REPORT_W-1:0] block_count;
    } sbt_result_t;

endpackage

FILE: sv/sbt_in_stage.sv
module sbt_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  sbt_pkg::sbt_item_t in_item,
    input  logic               out_ready,
    output logic               advance,
    output sbt_pkg::sbt_item_t item
);
    import sbt_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    sbt_item_t item_reg;
    logic      take;

    assign advance  = valid_reg && out_ready;
    assign in_stall = valid_reg && !out_ready;
    assign take     = in_valid && !in_stall;
    assign item     = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= in_item;
        end
    end

endmodule

FILE: sv/sbt_table.sv
`include "sack_block_table_defines.svh"

module sbt_table
#(
    parameter int MAX_BLOCKS = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_data,
    input  logic                 advance,
    input  sbt_pkg::sbt_item_t   item,
    output sbt_pkg::sbt_result_t result
);
    import sbt_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    logic                  sack_allowed_reg;
    logic [EDGE_W-1:0]     left_reg   [MAX_BLOCKS];
    logic [EDGE_W-1:0]     left_next  [MAX_BLOCKS];
    logic [EDGE_W-1:0]     right_reg  [MAX_BLOCKS];
    logic [EDGE_W-1:0]     right_next [MAX_BLOCKS];
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [MAX_BLOCKS-1:0] valid_vec;
    logic [MAX_BLOCKS-1:0] dup_vec;
    logic [MAX_BLOCKS-1:0] hit_vec;
    logic [MAX_BLOCKS-1:0] slot_vec;
    logic                  is_full;
    logic [CNT_W+2:0]      count_ext;

    // Entries below the count are live; each one is compared in parallel.
    always_comb
    begin
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            valid_vec[i] = count_reg > CNT_W'(i);
            dup_vec[i]   = valid_vec[i] && (left_reg[i] == item.left_edge)
                           && (right_reg[i] == item.right_edge);
            hit_vec[i]   = valid_vec[i] && (item.query_seq >= left_reg[i])
                           && (item.query_seq < right_reg[i]);
            slot_vec[i]  = count_reg == CNT_W'(i);
        end
    end

    assign is_full = count_reg == CNT_W'(MAX_BLOCKS);

    always_comb
    begin
        count_next = count_reg;
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            left_next[i]  = left_reg[i];
            right_next[i] = right_reg[i];
        end
        if (advance)
        begin
            case (item.opcode)
                OP_ADD:
                begin
                    if (sack_allowed_reg && !(|dup_vec))
                    begin
                        if (is_full)
                        begin
                            // The oldest block drops out of the front.
                            for (int i = 0; i < MAX_BLOCKS - 1; i++)
                            begin
                                left_next[i]  = left_reg[i+1];
                                right_next[i] = right_reg[i+1];
                            end
                            left_next[MAX_BLOCKS-1]  = item.left_edge;
                            right_next[MAX_BLOCKS-1] = item.right_edge;
                        end
                        else
                        begin
                            for (int i = 0; i < MAX_BLOCKS; i++)
                            begin
                                if (slot_vec[i])
                                begin
                                    left_next[i]  = item.left_edge;
                                    right_next[i] = item.right_edge;
                                end
                            end
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
                OP_CLEAR:
                begin
                    for (int i = 0; i < MAX_BLOCKS; i++)
                    begin
                        left_next[i]  = '0;
                        right_next[i] = '0;
                    end
                    count_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign count_ext          = {3'b000, count_next};
    assign result.hit         = (item.opcode == OP_QUERY) && (|hit_vec);
    assign result.block_count = count_ext[REPORT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sack_allowed_reg <= 1'b0;
            count_reg        <= '0;
            for (int i = 0; i < MAX_BLOCKS; i++)
            begin
                left_reg[i]  <= '0;
                right_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                sack_allowed_reg <= cfg_data;
            end
            count_reg <= count_next;
            for (int i = 0; i < MAX_BLOCKS; i++)
            begin
                left_reg[i]  <= left_next[i];
                right_reg[i] <= right_next[i];
            end
        end
    end

    `SBT_ASSERT(a_count_bound, count_reg <= CNT_W'(MAX_BLOCKS))
    `SBT_ASSERT(a_clear_empties, advance && item.opcode == OP_CLEAR |=> count_reg == '0)
    `SBT_ASSERT(a_add_blocked,
        advance && item.opcode == OP_ADD && !sack_allowed_reg |=> $stable(count_reg))
    `SBT_ASSERT(a_count_step,
        1'b1 |=> count_reg == $past(count_reg) || count_reg == $past(count_reg) + CNT_W'(1)
                 || count_reg == '0)

endmodule

FILE: sv/sbt_out_stage.sv
module sbt_out_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  sbt_pkg::sbt_result_t next_result,
    output logic                 out_ready,
    output logic                 out_valid,
    input  logic                 out_stall,
    output sbt_pkg::sbt_result_t result
);
    import sbt_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    sbt_result_t result_reg;

    assign out_ready = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= next_result;
        end
    end

endmodule

FILE: sv/sack_block_table.sv
// Selective-acknowledgment block table.
// Input channel: in_valid/in_stall with opcode, left_edge, right_edge and
// query_seq. An add stores a block when sack_allowed is set and the pair is new,
// shifting out the oldest block when the table is full; a query tests
// query_seq against every stored block; a clear empties the table.
// Output channel: out_valid/out_stall with hit and block_count, one result
// item for every input item, in order.
// The sack_allowed register is written through cfg_we and cfg_data.
// An item is captured in the input register; when it advances, the table
// is updated and the result register is loaded together.
// Throughput is one item per cycle unless the receiver stalls, set by the
// single compare-and-update pass over all entries between the registers.
// When the receiver stalls, the result register holds its item and the
// input register can still take one more item; further items are stalled.
// Reset empties the table, zeroes all entries and clears sack_allowed.
module sack_block_table
#(
    parameter int MAX_BLOCKS = 4
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic                               cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [sbt_pkg::OP_W-1:0]           opcode,
    input  logic [sbt_pkg::EDGE_W-1:0]         left_edge,
    input  logic [sbt_pkg::EDGE_W-1:0]         right_edge,
    input  logic [sbt_pkg::EDGE_W-1:0]         query_seq,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               hit,
    output logic [sbt_pkg::REPORT_W-1:0]       block_count
);
    import sbt_pkg::*;

    sbt_item_t   in_item;
    sbt_item_t   item;
    sbt_result_t next_result;
    sbt_result_t result;
    logic        advance;
    logic        out_ready;

    assign in_item.opcode     = opcode;
    assign in_item.left_edge  = left_edge;
    assign in_item.right_edge = right_edge;
    assign in_item.query_seq  = query_seq;

    sbt_in_stage u_in_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_ready (out_ready),
        .advance   (advance),
        .item      (item)
    );

    sbt_table #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_table
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .advance  (advance),
        .item     (item),
        .result   (next_result)
    );

    sbt_out_stage u_out_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .next_result (next_result),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result      (result)
    );

    assign hit         = result.hit;
    assign block_count = result.block_count;

endmodule
